// ----- src/mrrs_pkg.sv -----
`default_nettype none

package mrrs_pkg;

    // Default number of entries in each level's ring queue.
    localparam int QUEUE_DEPTH_DEF = 16;

    // Fixed field widths.
    localparam int LEVELS   = 3;
    localparam int LVL_W    = 2;
    localparam int ID_W     = 8;
    localparam int BURST_W  = 16;
    localparam int PRIO_W   = 8;
    localparam int QUANT_W  = 8;
    localparam int ENTRY_W  = ID_W + BURST_W;
    localparam int IN_W     = 32;
    localparam int OUT_W    = 16;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;

    // Level codes.
    localparam logic [LVL_W-1:0] LVL0 = 2'd0;
    localparam logic [LVL_W-1:0] LVL1 = 2'd1;
    localparam logic [LVL_W-1:0] LVL2 = 2'd2;

    // Request kinds carried in tuser.
    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_QUANT0 = 2'd0;
    localparam logic [1:0] REG_QUANT1 = 2'd1;
    localparam logic [1:0] REG_QUANT2 = 2'd2;

    // Control state of the scheduler.
    typedef enum logic
    {
        ST_IDLE,
        ST_RUN
    } state_t;

    // Queue bookkeeping request from the control logic.
    typedef struct packed
    {
        logic             push;
        logic [LVL_W-1:0] push_lvl;
        logic             pop;
        logic [LVL_W-1:0] pop_lvl;
    } qcmd_t;

endpackage

`default_nettype wire

// ----- src/multilevel_round_robin_scheduler.sv -----
// Results: an add request or a tick with a job already running gives its result in the cycle
// after acceptance; a tick that must fetch a new job passes through the registered read of the
// job memory and then the output register.
// Requests: no new request is taken while a fetched job is being read from the job memory; the
// output register must be empty or drained in the same cycle for a request to be accepted.
// Reset: queues empty, no job running, level zero current, all quanta 1; job memory is not cleared.
`default_nettype none

module multilevel_round_robin_scheduler #(
    parameter int QUEUE_DEPTH = mrrs_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // Bits: cmd [0]
    input  wire logic [0:0]                    s_axis_tuser,
    // Bits: job_id [7:0], burst_length [23:8], priority_level [31:24]
    input  wire logic [mrrs_pkg::IN_W-1:0]     s_axis_tdata,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // Bits: accepted [0], ran [1], running_id [9:2], served_level [11:10], completed [12]
    output logic      [mrrs_pkg::OUT_W-1:0]    m_axis_tdata,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [mrrs_pkg::APB_AW-1:0]   paddr,
    input  wire logic [mrrs_pkg::APB_DW-1:0]   pwdata,
    output logic      [mrrs_pkg::APB_DW-1:0]   prdata,
    output logic                               pready
);

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int DEPTH  = mrrs_pkg::LEVELS * QUEUE_DEPTH;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int ID_W   = mrrs_pkg::ID_W;
    localparam int BW     = mrrs_pkg::BURST_W;
    localparam int QW     = mrrs_pkg::QUANT_W;
    localparam int LW     = mrrs_pkg::LVL_W;

    mrrs_pkg::state_t state_reg;
    mrrs_pkg::state_t state_next;

    logic [LW-1:0]                  cur_reg;
    logic [LW-1:0]                  cur_next;
    logic                           active_reg;
    logic                           active_next;
    logic [mrrs_pkg::ENTRY_W-1:0]   job_reg;
    logic [mrrs_pkg::ENTRY_W-1:0]   job_next;
    logic [QW-1:0]                  slice_reg;
    logic [QW-1:0]                  slice_next;
    logic [mrrs_pkg::OUT_W-1:0]     out_data_reg;
    logic [mrrs_pkg::OUT_W-1:0]     out_data_next;
    logic                           out_valid_reg;
    logic                           out_load;

    logic [mrrs_pkg::LEVELS-1:0][QW-1:0]    quantum;
    logic [mrrs_pkg::LEVELS-1:0][CNT_W-1:0] cnt;
    mrrs_pkg::qcmd_t                qcmd;
    logic [ADDR_W-1:0]              wr_addr;
    logic [ADDR_W-1:0]              rd_addr;
    logic                           mem_we;
    logic [mrrs_pkg::ENTRY_W-1:0]   mem_wdata;
    logic [mrrs_pkg::ENTRY_W-1:0]   mem_rdata;

    logic                           accept;
    logic                           in_cmd;
    logic [ID_W-1:0]                in_id;
    logic [BW-1:0]                  in_burst;
    logic [mrrs_pkg::PRIO_W-1:0]    in_prio;
    logic [LW-1:0]                  in_lvl;
    logic [CNT_W:0]                 in_used;
    logic                           in_full;

    logic [LW-1:0]                  scan1;
    logic [LW-1:0]                  scan2;
    logic                           found;
    logic [LW-1:0]                  sel_lvl;
    logic [QW-1:0]                  sel_quant;

    logic [mrrs_pkg::ENTRY_W-1:0]   run_job;
    logic [BW-1:0]                  run_rem;
    logic [BW-1:0]                  ex_rem;
    logic [QW-1:0]                  ex_slice;
    logic                           ex_done;
    logic                           ex_requeue;
    logic [mrrs_pkg::ENTRY_W-1:0]   ex_job;
    logic [mrrs_pkg::OUT_W-1:0]     ex_result;

    mrrs_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .quantum (quantum)
    );

    mrrs_queues #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .PTR_W       (PTR_W),
        .CNT_W       (CNT_W),
        .ADDR_W      (ADDR_W)
    ) u_queues (
        .clk     (clk),
        .rst_n   (rst_n),
        .qcmd    (qcmd),
        .cnt     (cnt),
        .wr_addr (wr_addr),
        .rd_addr (rd_addr)
    );

    mrrs_ram #(
        .WIDTH (mrrs_pkg::ENTRY_W),
        .DEPTH (DEPTH)
    ) u_job_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (wr_addr),
        .wdata (mem_wdata),
        .raddr (rd_addr),
        .rdata (mem_rdata)
    );

    // Input request fields.
    assign s_axis_tready = (state_reg == mrrs_pkg::ST_IDLE) && (!out_valid_reg || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign in_cmd        = s_axis_tuser[0];
    assign in_id         = s_axis_tdata[7:0];
    assign in_burst      = s_axis_tdata[23:8];
    assign in_prio       = s_axis_tdata[31:24];

    // Level of an added job and its occupancy including a running job.
    always_comb
    begin
        if (in_prio == mrrs_pkg::PRIO_W'(0))
        begin
            in_lvl = mrrs_pkg::LVL0;
        end
        else if (in_prio == mrrs_pkg::PRIO_W'(1))
        begin
            in_lvl = mrrs_pkg::LVL1;
        end
        else
        begin
            in_lvl = mrrs_pkg::LVL2;
        end
    end

    assign in_used = {1'b0, cnt[in_lvl]} + (CNT_W + 1)'(active_reg && (cur_reg == in_lvl));
    assign in_full = in_used >= (CNT_W + 1)'(QUEUE_DEPTH);

    // Cyclic search for the first non-empty level starting at the current one.
    assign scan1 = (cur_reg == mrrs_pkg::LVL2) ? mrrs_pkg::LVL0 : cur_reg + LW'(1);
    assign scan2 = (cur_reg == mrrs_pkg::LVL0) ? mrrs_pkg::LVL2 : cur_reg - LW'(1);

    always_comb
    begin
        found   = 1'b1;
        sel_lvl = cur_reg;
        priority if (cnt[cur_reg] != '0)
        begin
            sel_lvl = cur_reg;
        end
        else if (cnt[scan1] != '0)
        begin
            sel_lvl = scan1;
        end
        else if (cnt[scan2] != '0)
        begin
            sel_lvl = scan2;
        end
        else
        begin
            found = 1'b0;
        end
    end

    // A quantum of zero behaves as one.
    assign sel_quant = (quantum[sel_lvl] == '0) ? QW'(1) : quantum[sel_lvl];

    // One tick of work on the running job, fresh from memory or held in registers.
    assign run_job    = (state_reg == mrrs_pkg::ST_RUN) ? mem_rdata : job_reg;
    assign run_rem    = run_job[BW-1:0];
    assign ex_rem     = (run_rem != '0) ? run_rem - BW'(1) : '0;
    assign ex_slice   = (slice_reg != '0) ? slice_reg - QW'(1) : '0;
    assign ex_done    = (ex_rem == '0);
    assign ex_requeue = !ex_done && (ex_slice == '0);
    assign ex_job     = {run_job[mrrs_pkg::ENTRY_W-1:BW], ex_rem};
    assign ex_result  = {3'b000, ex_done, cur_reg, run_job[mrrs_pkg::ENTRY_W-1:BW],
                         1'b1, 1'b0};

    // Control: next state, queue requests and result.
    always_comb
    begin
        state_next    = state_reg;
        cur_next      = cur_reg;
        active_next   = active_reg;
        job_next      = job_reg;
        slice_next    = slice_reg;
        qcmd          = '0;
        mem_we        = 1'b0;
        mem_wdata     = ex_job;
        out_load      = 1'b0;
        out_data_next = out_data_reg;

        unique case (state_reg)
            mrrs_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_cmd == mrrs_pkg::CMD_ADD)
                    begin
                        out_load      = 1'b1;
                        out_data_next = {{(mrrs_pkg::OUT_W - 1){1'b0}}, !in_full};
                        if (!in_full && (in_burst != '0))
                        begin
                            qcmd.push     = 1'b1;
                            qcmd.push_lvl = in_lvl;
                            mem_we        = 1'b1;
                            mem_wdata     = {in_id, in_burst};
                        end
                    end
                    else if (active_reg)
                    begin
                        out_load      = 1'b1;
                        out_data_next = ex_result;
                        active_next   = !ex_done && !ex_requeue;
                        job_next      = ex_job;
                        slice_next    = ex_done ? '0 : ex_slice;
                        if (ex_requeue)
                        begin
                            qcmd.push     = 1'b1;
                            qcmd.push_lvl = cur_reg;
                            mem_we        = 1'b1;
                        end
                    end
                    else if (found)
                    begin
                        qcmd.pop     = 1'b1;
                        qcmd.pop_lvl = sel_lvl;
                        cur_next     = sel_lvl;
                        slice_next   = sel_quant;
                        state_next   = mrrs_pkg::ST_RUN;
                    end
                    else
                    begin
                        out_load      = 1'b1;
                        out_data_next = '0;
                    end
                end
            end
            mrrs_pkg::ST_RUN:
            begin
                out_load      = 1'b1;
                out_data_next = ex_result;
                active_next   = !ex_done && !ex_requeue;
                job_next      = ex_job;
                slice_next    = ex_done ? '0 : ex_slice;
                state_next    = mrrs_pkg::ST_IDLE;
                if (ex_requeue)
                begin
                    qcmd.push     = 1'b1;
                    qcmd.push_lvl = cur_reg;
                    mem_we        = 1'b1;
                end
            end
            default:
            begin
                state_next = mrrs_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mrrs_pkg::ST_IDLE;
            cur_reg       <= mrrs_pkg::LVL0;
            active_reg    <= 1'b0;
            job_reg       <= '0;
            slice_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cur_reg    <= cur_next;
            active_reg <= active_next;
            job_reg    <= job_next;
            slice_reg  <= slice_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tvalid = out_valid_reg;

endmodule

`default_nettype wire

// ----- src/mrrs_ram.sv -----
`default_nettype none

module mrrs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 48
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one read port with registered data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- src/mrrs_cfg.sv -----
`default_nettype none

module mrrs_cfg (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [mrrs_pkg::APB_AW-1:0]    paddr,
    input  wire logic [mrrs_pkg::APB_DW-1:0]    pwdata,
    output logic      [mrrs_pkg::APB_DW-1:0]    prdata,
    output logic                                pready,
    output logic [mrrs_pkg::LEVELS-1:0][mrrs_pkg::QUANT_W-1:0] quantum
);

    logic [mrrs_pkg::QUANT_W-1:0] quant0_reg;
    logic [mrrs_pkg::QUANT_W-1:0] quant1_reg;
    logic [mrrs_pkg::QUANT_W-1:0] quant2_reg;
    logic                         wr_en;
    logic [1:0]                   reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    // Quantum registers; writes beyond the register list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quant0_reg <= mrrs_pkg::QUANT_W'(1);
            quant1_reg <= mrrs_pkg::QUANT_W'(1);
            quant2_reg <= mrrs_pkg::QUANT_W'(1);
        end
        else if (wr_en)
        begin
            if (reg_idx == mrrs_pkg::REG_QUANT0)
            begin
                quant0_reg <= pwdata[mrrs_pkg::QUANT_W-1:0];
            end
            if (reg_idx == mrrs_pkg::REG_QUANT1)
            begin
                quant1_reg <= pwdata[mrrs_pkg::QUANT_W-1:0];
            end
            if (reg_idx == mrrs_pkg::REG_QUANT2)
            begin
                quant2_reg <= pwdata[mrrs_pkg::QUANT_W-1:0];
            end
        end
    end

    // Read-back mux.
    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            mrrs_pkg::REG_QUANT0: prdata[mrrs_pkg::QUANT_W-1:0] = quant0_reg;
            mrrs_pkg::REG_QUANT1: prdata[mrrs_pkg::QUANT_W-1:0] = quant1_reg;
            mrrs_pkg::REG_QUANT2: prdata[mrrs_pkg::QUANT_W-1:0] = quant2_reg;
            default:              prdata = '0;
        endcase
    end

    assign quantum[0] = quant0_reg;
    assign quantum[1] = quant1_reg;
    assign quantum[2] = quant2_reg;

endmodule

`default_nettype wire

// ----- src/mrrs_queues.sv -----
`default_nettype none

module mrrs_queues #(
    parameter int QUEUE_DEPTH = mrrs_pkg::QUEUE_DEPTH_DEF,
    parameter int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
    parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1),
    parameter int ADDR_W      = $clog2(mrrs_pkg::LEVELS * QUEUE_DEPTH)
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire mrrs_pkg::qcmd_t       qcmd,
    output logic [mrrs_pkg::LEVELS-1:0][CNT_W-1:0] cnt,
    output logic      [ADDR_W-1:0]     wr_addr,
    output logic      [ADDR_W-1:0]     rd_addr
);

    localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [ADDR_W-1:0] BASE1    = ADDR_W'(QUEUE_DEPTH);
    localparam logic [ADDR_W-1:0] BASE2    = ADDR_W'(2 * QUEUE_DEPTH);

    logic [mrrs_pkg::LEVELS-1:0][PTR_W-1:0] head_reg;
    logic [mrrs_pkg::LEVELS-1:0][PTR_W-1:0] head_next;
    logic [mrrs_pkg::LEVELS-1:0][PTR_W-1:0] tail_reg;
    logic [mrrs_pkg::LEVELS-1:0][PTR_W-1:0] tail_next;
    logic [mrrs_pkg::LEVELS-1:0][CNT_W-1:0] cnt_reg;
    logic [mrrs_pkg::LEVELS-1:0][CNT_W-1:0] cnt_next;

    function automatic logic [ADDR_W-1:0] level_base(input logic [mrrs_pkg::LVL_W-1:0] lvl);
        logic [ADDR_W-1:0] b;
        unique case (lvl)
            mrrs_pkg::LVL0: b = '0;
            mrrs_pkg::LVL1: b = BASE1;
            mrrs_pkg::LVL2: b = BASE2;
            default:        b = '0;
        endcase
        return b;
    endfunction

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    // Memory addresses of the selected tail and head slots.
    assign wr_addr = level_base(qcmd.push_lvl) + ADDR_W'(tail_reg[qcmd.push_lvl]);
    assign rd_addr = level_base(qcmd.pop_lvl) + ADDR_W'(head_reg[qcmd.pop_lvl]);

    // Pointer and count updates per level.
    always_comb
    begin
        for (int i = 0; i < mrrs_pkg::LEVELS; i++)
        begin
            head_next[i] = head_reg[i];
            tail_next[i] = tail_reg[i];
            cnt_next[i]  = cnt_reg[i];
            if (qcmd.push && (qcmd.push_lvl == mrrs_pkg::LVL_W'(i)))
            begin
                tail_next[i] = ptr_inc(tail_reg[i]);
                cnt_next[i]  = cnt_next[i] + CNT_W'(1);
            end
            if (qcmd.pop && (qcmd.pop_lvl == mrrs_pkg::LVL_W'(i)))
            begin
                head_next[i] = ptr_inc(head_reg[i]);
                cnt_next[i]  = cnt_next[i] - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            cnt_reg  <= cnt_next;
        end
    end

    assign cnt = cnt_reg;

endmodule

`default_nettype wire
